FILE: hdl/ttla_pkg.sv
`default_nettype none

package ttla_pkg;

    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_COLOUR_MODE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FORE_COLOUR      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BACK_COLOUR      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SCROLLBACK_LINES = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BACKSPACE_CODE   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CR_CODE          = 3'd5;

    localparam logic [7:0] SPACE_CODE = 8'd32;
    localparam logic [7:0] LF_CODE    = 8'd10;

    localparam logic       RST_COLOUR_MODE      = 1'b1;
    localparam logic [3:0] RST_FORE_COLOUR      = 4'd15;
    localparam logic [3:0] RST_BACK_COLOUR      = 4'd0;
    localparam logic [7:0] RST_SCROLLBACK_LINES = 8'd200;
    localparam logic [7:0] RST_BACKSPACE_CODE   = 8'd8;
    localparam logic [7:0] RST_CR_CODE          = 8'd13;

    typedef struct packed {
        logic       colour_mode;
        logic [3:0] fore_colour;
        logic [3:0] back_colour;
        logic [7:0] scrollback_lines;
        logic [7:0] backspace_code;
        logic [7:0] cr_code;
    } cfg_t;

endpackage

`default_nettype wire

FILE: hdl/ttla_ram.sv
`default_nettype none

module ttla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/ttla_cfg.sv
`default_nettype none

module ttla_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ttla_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [7:0]                        cfg_data,
    output ttla_pkg::cfg_t                         cfg
);

    ttla_pkg::cfg_t cfg_reg;
    ttla_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                ttla_pkg::REG_COLOUR_MODE:      cfg_next.colour_mode      = cfg_data[0];
                ttla_pkg::REG_FORE_COLOUR:      cfg_next.fore_colour      = cfg_data[3:0];
                ttla_pkg::REG_BACK_COLOUR:      cfg_next.back_colour      = cfg_data[3:0];
                ttla_pkg::REG_SCROLLBACK_LINES: cfg_next.scrollback_lines = cfg_data;
                ttla_pkg::REG_BACKSPACE_CODE:   cfg_next.backspace_code   = cfg_data;
                ttla_pkg::REG_CR_CODE:          cfg_next.cr_code          = cfg_data;
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.colour_mode      <= ttla_pkg::RST_COLOUR_MODE;
            cfg_reg.fore_colour      <= ttla_pkg::RST_FORE_COLOUR;
            cfg_reg.back_colour      <= ttla_pkg::RST_BACK_COLOUR;
            cfg_reg.scrollback_lines <= ttla_pkg::RST_SCROLLBACK_LINES;
            cfg_reg.backspace_code   <= ttla_pkg::RST_BACKSPACE_CODE;
            cfg_reg.cr_code          <= ttla_pkg::RST_CR_CODE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/text_terminal_line_assembler_top.sv
// An ordinary character or backspace gives its acknowledge from the output register. A line
// flush sends its cells through the memory read register, then the output register, one per
// cycle while out_stall is low. Throughput: one character per cycle while in_stall is low;
// a flush stalls input while the single read port of the cell memories walks each cell.
// Reset: asynchronous, active low; cells read as blank with attribute 0x0F through per-cell
// valid bits, so no clearing pass is needed and the block takes items right after reset.
`default_nettype none

module text_terminal_line_assembler_top #(
    parameter int CHARS_PER_LINE = 60
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [7:0]                        char_code,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   is_line_write,
    output logic                                   status,
    output logic [14:0]                            cell_address,
    output logic [7:0]                             cell_char,
    output logic [7:0]                             cell_attr,
    output logic [7:0]                             line_slot,
    output logic [7:0]                             lines_held,
    output logic                                   last,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ttla_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [7:0]                        cfg_data
);

    localparam int IDX_W = $clog2(CHARS_PER_LINE);
    localparam int CUR_W = $clog2(CHARS_PER_LINE + 1);

    typedef enum logic {ST_IDLE, ST_EMIT} state_t;

    ttla_pkg::cfg_t cfg;

    ttla_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    state_t                  state_reg;
    logic [CUR_W-1:0]        cursor_reg;
    logic [7:0]              ring_slot_reg;
    logic [7:0]              line_total_reg;
    logic [7:0]              flush_slot_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [14:0]             addr_run_reg;
    logic [CHARS_PER_LINE-1:0] char_vld_reg;
    logic [CHARS_PER_LINE-1:0] attr_vld_reg;
    logic                    char_vld_q_reg;
    logic                    attr_vld_q_reg;
    logic [7:0]              blank_attr_reg;

    logic                    out_valid_reg;
    logic                    is_line_write_reg;
    logic                    status_reg;
    logic [14:0]             cell_address_reg;
    logic [7:0]              cell_char_reg;
    logic [7:0]              cell_attr_reg;
    logic [7:0]              line_slot_reg;
    logic [7:0]              lines_held_reg;
    logic                    last_reg;

    logic [7:0]        cur_attr;
    logic              out_free;
    logic              in_xfer;
    logic              is_flush;
    logic              is_bs;
    logic [IDX_W-1:0]  cur_idx;
    logic              wr_char_en;
    logic              wr_attr_en;
    logic [7:0]        wr_char;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [7:0]        ch_rdata;
    logic [7:0]        at_rdata;
    logic [8:0]        total_inc;
    logic [7:0]        total_new;
    logic [8:0]        slot_inc;
    logic [14:0]       line_base;
    logic              emit_last;

    assign cur_attr  = {cfg.back_colour, cfg.fore_colour};
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE) || !out_free;
    assign in_xfer   = in_valid && !in_stall;
    assign cur_idx   = cursor_reg[IDX_W-1:0];
    assign is_flush  = (cursor_reg == CUR_W'(CHARS_PER_LINE))
                       || (char_code == cfg.cr_code) || (char_code == ttla_pkg::LF_CODE);
    assign is_bs     = (char_code == cfg.backspace_code);
    assign emit_last = (idx_reg == IDX_W'(CHARS_PER_LINE - 1));

    // Backspace blanks the cell under the cursor; column 0 leaves the line untouched.
    assign wr_char_en = in_xfer && !is_flush && (!is_bs || (cursor_reg != '0));
    assign wr_attr_en = wr_char_en && cfg.colour_mode;
    assign wr_char    = is_bs ? ttla_pkg::SPACE_CODE : char_code;

    assign total_inc = {1'b0, line_total_reg} + 9'd1;
    assign total_new = (total_inc >= {1'b0, cfg.scrollback_lines})
                       ? cfg.scrollback_lines : total_inc[7:0];
    assign slot_inc  = {1'b0, ring_slot_reg} + 9'd1;
    assign line_base = 15'({7'b0, ring_slot_reg} * 15'(CHARS_PER_LINE));

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (in_xfer && is_flush)
        begin
            rd_en = 1'b1;
        end
        else if (state_reg == ST_EMIT && out_free && !emit_last)
        begin
            rd_en   = 1'b1;
            rd_addr = idx_reg + IDX_W'(1);
        end
    end

    ttla_ram #(
        .WIDTH (8),
        .DEPTH (CHARS_PER_LINE)
    ) u_char_ram (
        .clk     (clk),
        .wr_en   (wr_char_en),
        .wr_addr (cur_idx),
        .wr_data (wr_char),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ch_rdata)
    );

    ttla_ram #(
        .WIDTH (8),
        .DEPTH (CHARS_PER_LINE)
    ) u_attr_ram (
        .clk     (clk),
        .wr_en   (wr_attr_en),
        .wr_addr (cur_idx),
        .wr_data (cur_attr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (at_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            cursor_reg        <= '0;
            ring_slot_reg     <= '0;
            line_total_reg    <= 8'd1;
            flush_slot_reg    <= '0;
            addr_run_reg      <= '0;
            char_vld_reg      <= '0;
            attr_vld_reg      <= '0;
            char_vld_q_reg    <= 1'b0;
            attr_vld_q_reg    <= 1'b0;
            blank_attr_reg    <= {ttla_pkg::RST_BACK_COLOUR, ttla_pkg::RST_FORE_COLOUR};
            out_valid_reg     <= 1'b0;
            is_line_write_reg <= 1'b0;
            status_reg        <= 1'b0;
            cell_address_reg  <= '0;
            cell_char_reg     <= '0;
            cell_attr_reg     <= '0;
            line_slot_reg     <= '0;
            lines_held_reg    <= '0;
            last_reg          <= 1'b0;
            idx_reg           <= '0;
        end
        else
        begin
            // A free output register takes an acknowledge or the next cell, else it empties.
            if (out_free)
            begin
                out_valid_reg <= (in_xfer && !is_flush) || (state_reg == ST_EMIT);
            end
            if (rd_en)
            begin
                char_vld_q_reg <= char_vld_reg[rd_addr];
                attr_vld_q_reg <= attr_vld_reg[rd_addr];
            end
            if (wr_char_en)
            begin
                char_vld_reg[cur_idx] <= 1'b1;
            end
            if (wr_attr_en)
            begin
                attr_vld_reg[cur_idx] <= 1'b1;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer && is_flush)
                    begin
                        state_reg      <= ST_EMIT;
                        idx_reg        <= '0;
                        flush_slot_reg <= ring_slot_reg;
                        addr_run_reg   <= cfg.colour_mode ? {line_base[13:0], 1'b0}
                                                          : line_base;
                        line_total_reg <= total_new;
                        cursor_reg     <= '0;
                        ring_slot_reg  <= (slot_inc >= {1'b0, cfg.scrollback_lines})
                                          ? 8'd0 : slot_inc[7:0];
                    end
                    else if (in_xfer)
                    begin
                        if (!is_bs)
                        begin
                            cursor_reg <= cursor_reg + CUR_W'(1);
                        end
                        else if (cursor_reg != '0)
                        begin
                            cursor_reg <= cursor_reg - CUR_W'(1);
                        end
                        is_line_write_reg <= 1'b0;
                        status_reg        <= 1'b0;
                        cell_address_reg  <= '0;
                        cell_char_reg     <= '0;
                        cell_attr_reg     <= '0;
                        line_slot_reg     <= ring_slot_reg;
                        lines_held_reg    <= line_total_reg;
                        last_reg          <= 1'b1;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        is_line_write_reg <= 1'b1;
                        status_reg        <= 1'b1;
                        cell_address_reg  <= addr_run_reg;
                        cell_char_reg     <= char_vld_q_reg ? ch_rdata : ttla_pkg::SPACE_CODE;
                        cell_attr_reg     <= !cfg.colour_mode ? 8'd0
                                             : (attr_vld_q_reg ? at_rdata : blank_attr_reg);
                        line_slot_reg     <= flush_slot_reg;
                        lines_held_reg    <= line_total_reg;
                        last_reg          <= emit_last;
                        addr_run_reg      <= addr_run_reg + (cfg.colour_mode ? 15'd2 : 15'd1);
                        idx_reg           <= idx_reg + IDX_W'(1);
                        if (emit_last)
                        begin
                            // The line is blanked in one step with the colours of this moment.
                            state_reg      <= ST_IDLE;
                            char_vld_reg   <= '0;
                            attr_vld_reg   <= '0;
                            blank_attr_reg <= cur_attr;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign is_line_write = is_line_write_reg;
    assign status        = status_reg;
    assign cell_address  = cell_address_reg;
    assign cell_char     = cell_char_reg;
    assign cell_attr     = cell_attr_reg;
    assign line_slot     = line_slot_reg;
    assign lines_held    = lines_held_reg;
    assign last          = last_reg;

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= CUR_W'(CHARS_PER_LINE))
        else $error("cursor beyond end of line");

    a_flush_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && is_flush) |=> in_stall)
        else $error("input not held during line flush");

    a_ack_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !is_line_write_reg) |-> last_reg)
        else $error("acknowledge without last mark");

    a_slot_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_xfer && is_flush) |=> $stable(ring_slot_reg))
        else $error("ring slot moved outside a flush");

    a_no_write_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !wr_char_en)
        else $error("cell written while the line is being flushed");

endmodule

`default_nettype wire
